@@ rtl/fir_pkg.sv @@
// Shared constants, types and codes of the direct-form FIR filter.
// No dependencies; used by fir_mac, fir_filter_core, fir_chk and the bench.
package fir_pkg;

  localparam int MAX_TAPS    = 32;   // power of two: the delay ring wraps on it
  localparam int SAMPLE_BITS = 16;

  localparam int ADDR_W  = $clog2(MAX_TAPS);
  localparam int FILL_W  = $clog2(MAX_TAPS + 1);
  localparam int TAP_W   = 6;
  localparam int SLOT_W  = 5;
  localparam int FRAC_W  = SAMPLE_BITS - 1;
  localparam int PROD_W  = 2 * SAMPLE_BITS;
  localparam int ACC_W   = PROD_W + ADDR_W + 1;
  localparam int SHF_W   = ACC_W - FRAC_W;

  localparam logic [TAP_W-1:0]  TAP_RESET = TAP_W'(23);
  localparam logic [ACC_W-1:0]  RND_HALF  = ACC_W'(1) << (FRAC_W - 1);

  localparam logic [SAMPLE_BITS-1:0] SAT_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic [SAMPLE_BITS-1:0] SAT_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  localparam logic CMD_LOAD   = 1'b0;
  localparam logic CMD_SAMPLE = 1'b1;

  // read issue tag, aligned with the RAM read data
  typedef struct packed {
    logic vld;
    logic last;
    logic keep;   // delay entry holds a real sample, else it reads as zero
  } rd_tag_t;

  typedef struct packed {
    logic    clr;
    rd_tag_t tag;
  } mac_ctrl_t;

endpackage

@@ rtl/fir_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
module fir_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/fir_mac.sv @@
// Multiply-accumulate datapath: product register, wide accumulator,
// rounding and saturation to Q1.15. Depends on fir_pkg.
module fir_mac (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  fir_pkg::mac_ctrl_t                 ctrl_i,
  input  logic signed [fir_pkg::SAMPLE_BITS-1:0] coef_i,
  input  logic signed [fir_pkg::SAMPLE_BITS-1:0] samp_i,
  output logic                               done_o,
  output logic signed [fir_pkg::SAMPLE_BITS-1:0] filtered_o,
  output logic                               saturated_o
);

  logic signed [fir_pkg::PROD_W-1:0] prod_full;
  logic signed [fir_pkg::PROD_W-1:0] prod_d, prod_q;
  logic                              p_vld_q, p_last_q;
  logic signed [fir_pkg::ACC_W-1:0]  acc_d, acc_q;
  logic                              done_q;
  logic        [fir_pkg::ACC_W-1:0]  rnd;
  logic        [fir_pkg::SHF_W-1:0]  shf;
  logic                              ovf_hi, ovf_lo;

  // signed 16x16 product, sized on its own so both operands sign-extend
  assign prod_full = coef_i * samp_i;
  assign prod_d    = ctrl_i.tag.keep ? prod_full : '0;

  always_comb begin
    acc_d = acc_q;
    if (ctrl_i.clr) begin
      acc_d = '0;
    end else if (p_vld_q) begin
      acc_d = acc_q + {{(fir_pkg::ACC_W-fir_pkg::PROD_W){prod_q[fir_pkg::PROD_W-1]}}, prod_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_vld_q  <= 1'b0;
      p_last_q <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      p_vld_q  <= ctrl_i.tag.vld;
      p_last_q <= ctrl_i.tag.last;
      done_q   <= p_vld_q & p_last_q;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    acc_q  <= acc_d;
  end

  // round half up, arithmetic shift, then clip to Q1.15
  assign rnd    = acc_q + fir_pkg::RND_HALF;
  assign shf    = rnd[fir_pkg::ACC_W-1:fir_pkg::FRAC_W];
  assign ovf_hi = !shf[fir_pkg::SHF_W-1] && (|shf[fir_pkg::SHF_W-2:fir_pkg::SAMPLE_BITS-1]);
  assign ovf_lo = shf[fir_pkg::SHF_W-1] && !(&shf[fir_pkg::SHF_W-2:fir_pkg::SAMPLE_BITS-1]);

  assign done_o      = done_q;
  assign saturated_o = ovf_hi | ovf_lo;
  assign filtered_o  = ovf_hi ? fir_pkg::SAT_MAX :
                       ovf_lo ? fir_pkg::SAT_MIN : shf[fir_pkg::SAMPLE_BITS-1:0];

endmodule

@@ rtl/fir_filter_core.sv @@
// Top level of the direct-form FIR filter: sequencer, coefficient RAM,
// delay-line ring RAM and output register. Depends on fir_pkg, fir_ram, fir_mac.
//
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  in      | in_valid_i/in_ready_o, cmd, coef_index, value | to block
//  out     | out_valid_o/out_ready_i, filtered, saturated  | from block
//  cfg     | cfg_valid_i/cfg_ready_o, tap_count          | to block
//
// A coefficient load is written into the coefficient RAM when it is accepted. A sample
// issues one read of each RAM per tap; the data then pass the RAM read register,
// the product register and the accumulator before the output register is loaded.
// Reset clears the sequencer, the ring pointer and the fill count and sets tap_count
// to 23; delay entries not yet written since reset read as zero through the fill count.
// A full output register holds the sequencer in ST_OUT; no new word is accepted until then.
module fir_filter_core (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   in_valid_i,
  output logic                                   in_ready_o,
  input  logic                                   cmd_i,
  input  logic [fir_pkg::SLOT_W-1:0]             coef_index_i,
  input  logic signed [fir_pkg::SAMPLE_BITS-1:0] value_i,
  output logic                                   out_valid_o,
  input  logic                                   out_ready_i,
  output logic signed [fir_pkg::SAMPLE_BITS-1:0] filtered_o,
  output logic                                   saturated_o,
  input  logic                                   cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  logic [fir_pkg::TAP_W-1:0]              tap_count_i
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_OUT
  } state_e;

  state_e                            state_q, state_d;
  logic [fir_pkg::TAP_W-1:0]         tap_count_q;
  logic [fir_pkg::ADDR_W-1:0]        wp_q, cur_q, k_q, k_d, last_q, last_d;
  logic [fir_pkg::FILL_W-1:0]        fill_q;
  logic                              out_valid_q;
  logic [fir_pkg::SAMPLE_BITS-1:0]   filtered_q;
  logic                              saturated_q;
  fir_pkg::rd_tag_t                  tag_d, tag_q;
  fir_pkg::mac_ctrl_t                mac_ctrl;

  logic                              in_acc, ld_acc, smp_acc, out_load;
  logic                              coef_we;
  logic [fir_pkg::SAMPLE_BITS-1:0]   coef_rdata, dly_rdata;
  logic [fir_pkg::ADDR_W-1:0]        dly_raddr;
  logic                              mac_done, mac_sat;
  logic signed [fir_pkg::SAMPLE_BITS-1:0] mac_y;
  logic [fir_pkg::TAP_W-1:0]         taps_eff;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign cfg_ready_o = 1'b1;
  assign in_acc      = in_valid_i && in_ready_o;
  assign ld_acc      = in_acc && (cmd_i == fir_pkg::CMD_LOAD);
  assign smp_acc     = in_acc && (cmd_i == fir_pkg::CMD_SAMPLE);
  assign out_load    = (state_q == ST_OUT) && (!out_valid_q || out_ready_i);
  assign coef_we     = ld_acc &&
                       ({1'b0, coef_index_i} < (fir_pkg::SLOT_W+1)'(fir_pkg::MAX_TAPS));

  // zero taps act as one, too many are clipped to the table size
  always_comb begin
    taps_eff = tap_count_q;
    if (tap_count_q == '0) begin
      taps_eff = fir_pkg::TAP_W'(1);
    end else if (tap_count_q > fir_pkg::TAP_W'(fir_pkg::MAX_TAPS)) begin
      taps_eff = fir_pkg::TAP_W'(fir_pkg::MAX_TAPS);
    end
  end

  always_comb begin
    state_d = state_q;
    k_d     = k_q;
    last_d  = last_q;
    tag_d   = '0;
    case (state_q)
      ST_IDLE: begin
        if (smp_acc) begin
          state_d = ST_RUN;
          k_d     = '0;
          last_d  = fir_pkg::ADDR_W'(taps_eff - fir_pkg::TAP_W'(1));
        end
      end
      ST_RUN: begin
        tag_d.vld  = 1'b1;
        tag_d.last = (k_q == last_q);
        tag_d.keep = (fir_pkg::FILL_W'(k_q) < fill_q);
        k_d        = k_q + fir_pkg::ADDR_W'(1);
        if (k_q == last_q) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (mac_done) begin
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      tap_count_q <= fir_pkg::TAP_RESET;
      wp_q        <= '0;
      cur_q       <= '0;
      fill_q      <= '0;
      k_q         <= '0;
      last_q      <= '0;
      tag_q       <= '0;
      out_valid_q <= 1'b0;
      filtered_q  <= '0;
      saturated_q <= 1'b0;
    end else begin
      state_q <= state_d;
      k_q     <= k_d;
      last_q  <= last_d;
      tag_q   <= tag_d;
      if (cfg_valid_i && cfg_ready_o) begin
        tap_count_q <= tap_count_i;
      end
      if (smp_acc) begin
        cur_q <= wp_q;
        wp_q  <= wp_q + fir_pkg::ADDR_W'(1);
        if (fill_q != fir_pkg::FILL_W'(fir_pkg::MAX_TAPS)) begin
          fill_q <= fill_q + fir_pkg::FILL_W'(1);
        end
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
        filtered_q  <= mac_y;
        saturated_q <= mac_sat;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // age k of the current sample sits k slots behind it in the ring
  assign dly_raddr = cur_q - k_q;

  fir_ram #(
    .WIDTH (fir_pkg::SAMPLE_BITS),
    .DEPTH (fir_pkg::MAX_TAPS)
  ) u_coef_ram (
    .clk_i   (clk_i),
    .we_i    (coef_we),
    .waddr_i (coef_index_i[fir_pkg::ADDR_W-1:0]),
    .wdata_i (value_i),
    .raddr_i (k_q),
    .rdata_o (coef_rdata)
  );

  fir_ram #(
    .WIDTH (fir_pkg::SAMPLE_BITS),
    .DEPTH (fir_pkg::MAX_TAPS)
  ) u_dly_ram (
    .clk_i   (clk_i),
    .we_i    (smp_acc),
    .waddr_i (wp_q),
    .wdata_i (value_i),
    .raddr_i (dly_raddr),
    .rdata_o (dly_rdata)
  );

  assign mac_ctrl.clr = smp_acc;
  assign mac_ctrl.tag = tag_q;

  fir_mac u_mac (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (mac_ctrl),
    .coef_i      (coef_rdata),
    .samp_i      (dly_rdata),
    .done_o      (mac_done),
    .filtered_o  (mac_y),
    .saturated_o (mac_sat)
  );

  assign out_valid_o = out_valid_q;
  assign filtered_o  = filtered_q;
  assign saturated_o = saturated_q;

endmodule

@@ rtl/fir_chk.sv @@
// Port-level checker for fir_filter_core, bound to every instance.
// Depends on fir_pkg.
module fir_chk (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             in_valid_i,
  input logic                             in_ready_o,
  input logic                             cmd_i,
  input logic                             out_valid_o,
  input logic                             out_ready_i,
  input logic [fir_pkg::SAMPLE_BITS-1:0]  filtered_o,
  input logic                             saturated_o
);

  // a waiting result word stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(filtered_o) && $stable(saturated_o))
    else $error("result word changed while stalled");

  // a sample keeps the input closed while taps are processed
  a_smp_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && cmd_i == fir_pkg::CMD_SAMPLE |=> !in_ready_o)
    else $error("input open right after a sample");

  // a coefficient load makes no result
  a_load_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && cmd_i == fir_pkg::CMD_LOAD && !out_valid_o |=> !out_valid_o)
    else $error("result word after a coefficient load");

  // clipping only ever yields a range limit
  a_sat_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && saturated_o |->
      filtered_o == fir_pkg::SAT_MAX || filtered_o == fir_pkg::SAT_MIN)
    else $error("saturated flag with an in-range value");

endmodule

bind fir_filter_core fir_chk u_fir_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .cmd_i       (cmd_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .filtered_o  (filtered_o),
  .saturated_o (saturated_o)
);

@@ bench/tb_top.sv @@
`timescale 1ns / 100ps
// Self-checking bench for fir_filter_core: coefficient loads and samples go in through
// valid/ready with random gaps, outputs are checked against an in-bench convolution.
// Depends on fir_pkg and fir_filter_core.
module tb_top;

  localparam int     SW           = fir_pkg::SAMPLE_BITS;
  localparam int     DRAIN_CYCLES = fir_pkg::MAX_TAPS + 20;
  localparam longint Q15_TOP      = (longint'(1) <<< fir_pkg::FRAC_W) - 1;
  localparam longint Q15_BOT      = -Q15_TOP - 1;
  localparam logic signed [SW-1:0] HALF_UP = SW'(1) << (fir_pkg::FRAC_W - 1);

  typedef struct packed {
    logic                          cmd;
    logic [fir_pkg::SLOT_W-1:0]    slot;
    logic signed [SW-1:0]          value;
  } fir_in_word_t;

  typedef struct packed {
    logic signed [SW-1:0] filtered;
    logic                 saturated;
  } fir_out_word_t;

  logic                       clk_i        = 1'b0;
  logic                       rst_ni       = 1'b0;
  logic                       in_valid_i   = 1'b0;
  logic                       in_ready_o;
  logic                       cmd_i        = fir_pkg::CMD_LOAD;
  logic [fir_pkg::SLOT_W-1:0] coef_index_i = '0;
  logic signed [SW-1:0]       value_i      = '0;
  logic                       out_valid_o;
  logic                       out_ready_i  = 1'b0;
  logic signed [SW-1:0]       filtered_o;
  logic                       saturated_o;
  logic                       cfg_valid_i  = 1'b0;
  logic                       cfg_ready_o;
  logic [fir_pkg::TAP_W-1:0]  tap_count_i  = fir_pkg::TAP_RESET;

  // filter state as the block should hold it
  logic signed [SW-1:0]      coef_tbl    [fir_pkg::MAX_TAPS] = '{default: '0};
  logic signed [SW-1:0]      sample_hist [fir_pkg::MAX_TAPS] = '{default: '0};
  logic [fir_pkg::TAP_W-1:0] tap_setting = fir_pkg::TAP_RESET;
  logic [fir_pkg::TAP_W-1:0] tap_plan [7] = '{6'd32, 6'd0, 6'd63, 6'd7, 6'd23, 6'd1, 6'd16};

  fir_in_word_t                in_words[$];
  fir_out_word_t               outputs_due[$];
  logic [fir_pkg::MAX_TAPS-1:0] coef_loaded = '0;  // slots already queued for load
  int unsigned                 idle_pct    = 0;
  int unsigned                 send_gap    = 0;
  int unsigned                 ready_gap   = 0;
  logic                        in_accepted = 1'b0;
  int                          fail_count  = 0;

  fir_filter_core i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .cmd_i        (cmd_i),
    .coef_index_i (coef_index_i),
    .value_i      (value_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .filtered_o   (filtered_o),
    .saturated_o  (saturated_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .tap_count_i  (tap_count_i)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic int unsigned active_taps(logic [fir_pkg::TAP_W-1:0] setting);
    if (setting == 0) return 1;
    if (setting > fir_pkg::MAX_TAPS) return fir_pkg::MAX_TAPS;
    return 32'(setting);
  endfunction

  function automatic int unsigned pick_gap();
    if ($urandom_range(99) >= idle_pct) return 0;
    if ($urandom_range(7) == 0) return $urandom_range(60, 20);
    return $urandom_range(3, 1);
  endfunction

  function automatic logic signed [SW-1:0] rand_value();
    int unsigned pick;
    pick = $urandom_range(9);
    if (pick == 0) return fir_pkg::SAT_MAX;
    if (pick == 1) return fir_pkg::SAT_MIN;
    if (pick == 2) return SW'(int'($urandom_range(512)) - 256);
    return SW'($urandom);
  endfunction

  // shift the sample in, then multiply-accumulate, round half up, saturate
  function automatic fir_out_word_t convolve_sample(logic signed [SW-1:0] x);
    int unsigned   n_taps;
    longint        acc;
    longint        y;
    fir_out_word_t r;
    n_taps = active_taps(tap_setting);
    for (int k = fir_pkg::MAX_TAPS - 1; k > 0; k--) sample_hist[k] = sample_hist[k-1];
    sample_hist[0] = x;
    acc = 0;
    for (int k = 0; k < n_taps; k++) acc += longint'(coef_tbl[k]) * longint'(sample_hist[k]);
    y = (acc + (longint'(1) <<< (fir_pkg::FRAC_W - 1))) >>> fir_pkg::FRAC_W;
    r.saturated = 1'b1;
    if (y > Q15_TOP) y = Q15_TOP;
    else if (y < Q15_BOT) y = Q15_BOT;
    else r.saturated = 1'b0;
    r.filtered = y[SW-1:0];
    return r;
  endfunction

  task automatic push_load(logic [fir_pkg::SLOT_W-1:0] slot, logic signed [SW-1:0] val);
    in_words.push_back('{cmd: fir_pkg::CMD_LOAD, slot: slot, value: val});
    coef_loaded[slot] = 1'b1;
  endtask

  task automatic push_sample(logic signed [SW-1:0] val);
    in_words.push_back('{cmd: fir_pkg::CMD_SAMPLE, slot: fir_pkg::SLOT_W'($urandom),
                         value: val});
  endtask

  // no sample may read a coefficient slot that was never loaded
  task automatic ensure_coefs(int unsigned n);
    for (int k = 0; k < n; k++)
      if (!coef_loaded[k]) push_load(fir_pkg::SLOT_W'(k), rand_value());
  endtask

  task automatic wait_idle();
    while (in_words.size() != 0 || in_valid_i || outputs_due.size() != 0) @(posedge clk_i);
    // the input and ready drivers may still be counting down a random gap
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_taps(logic [fir_pkg::TAP_W-1:0] setting);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    tap_count_i <= setting;
    do @(posedge clk_i); while (!cfg_ready_o);
    tap_setting = setting;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic random_phase(int unsigned n_words);
    int unsigned taps;
    taps = active_taps(tap_setting);
    repeat (n_words) begin
      if ($urandom_range(99) < 20) begin
        push_load(fir_pkg::SLOT_W'($urandom_range(fir_pkg::MAX_TAPS - 1)), rand_value());
      end else begin
        ensure_coefs(taps);
        push_sample(rand_value());
      end
    end
  endtask

  initial begin : stimulus
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // single tap: full-scale products, saturation on the high side, rounding ties
    write_taps(6'd1);
    push_load(fir_pkg::SLOT_W'(0), fir_pkg::SAT_MAX);
    push_sample(fir_pkg::SAT_MAX);
    push_sample(fir_pkg::SAT_MIN);
    push_sample('0);
    push_load(fir_pkg::SLOT_W'(0), fir_pkg::SAT_MIN);
    push_sample(fir_pkg::SAT_MIN);
    push_sample(fir_pkg::SAT_MAX);
    push_load(fir_pkg::SLOT_W'(0), SW'(1));
    push_sample(HALF_UP);
    push_sample(-HALF_UP);
    push_sample('1);
    push_load(fir_pkg::SLOT_W'(fir_pkg::MAX_TAPS - 1), fir_pkg::SAT_MIN);
    push_load(fir_pkg::SLOT_W'(0), fir_pkg::SAT_MIN);
    wait_idle();

    // two taps: sums beyond one full scale
    write_taps(6'd2);
    push_load(fir_pkg::SLOT_W'(1), fir_pkg::SAT_MIN);
    push_sample(fir_pkg::SAT_MAX);
    push_sample(fir_pkg::SAT_MAX);
    push_sample(fir_pkg::SAT_MIN);
    push_sample(fir_pkg::SAT_MIN);
    wait_idle();

    // few samples so far, so the first full-length pass still sees cleared history
    for (int p = 0; p < 9; p++) begin
      case ($urandom_range(3))
        0:       idle_pct = 0;
        1:       idle_pct = 15;
        2:       idle_pct = 40;
        default: idle_pct = 70;
      endcase
      write_taps((p < 7) ? tap_plan[p] : fir_pkg::TAP_W'($urandom_range(63)));
      random_phase(70);
      wait_idle();
    end

    if (fail_count == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

  initial begin : watchdog
    #1_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  always @(negedge clk_i) begin : word_driver
    fir_in_word_t w;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (in_valid_i && !in_accepted) begin
      // word still on offer
    end else if (send_gap != 0) begin
      in_valid_i <= 1'b0;
      send_gap   <= send_gap - 1;
    end else if (in_words.size() != 0) begin
      w = in_words.pop_front();
      cmd_i        <= w.cmd;
      coef_index_i <= w.slot;
      value_i      <= w.value;
      in_valid_i   <= 1'b1;
      send_gap     <= pick_gap();
    end else begin
      in_valid_i <= 1'b0;
    end
  end

  always @(negedge clk_i) begin : ready_driver
    int unsigned stall;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else if (ready_gap != 0) begin
      out_ready_i <= 1'b0;
      ready_gap   <= ready_gap - 1;
    end else begin
      stall = ($urandom_range(3) == 0) ? pick_gap() : 0;
      out_ready_i <= (stall == 0);
      ready_gap   <= (stall == 0) ? 0 : stall - 1;
    end
  end

  always @(posedge clk_i) begin : word_monitor
    fir_out_word_t want;
    in_accepted <= in_valid_i && in_ready_o;
    if (in_valid_i && in_ready_o) begin
      if (cmd_i == fir_pkg::CMD_LOAD) coef_tbl[coef_index_i] = value_i;
      else outputs_due.push_back(convolve_sample(value_i));
    end
    if (out_valid_o && out_ready_i) begin
      if (outputs_due.size() == 0) begin
        $display("%0t: output word with none due: filtered %0d saturated %0b",
                 $time, filtered_o, saturated_o);
        fail_count++;
      end else begin
        want = outputs_due.pop_front();
        if (filtered_o !== want.filtered) begin
          $display("%0t: filtered expected %0d actual %0d", $time, want.filtered, filtered_o);
          fail_count++;
        end
        if (saturated_o !== want.saturated) begin
          $display("%0t: saturated expected %0b actual %0b",
                   $time, want.saturated, saturated_o);
          fail_count++;
        end
      end
    end
  end

endmodule

@@ filelist.f @@
rtl/fir_pkg.sv
rtl/fir_ram.sv
rtl/fir_mac.sv
rtl/fir_filter_core.sv
rtl/fir_chk.sv
bench/tb_top.sv
